// ----- rtl/turret_motor_drive_controller_defines.svh -----
// Assertion macros shared by the turret motor drive RTL.
`ifndef TURRET_MOTOR_DRIVE_CONTROLLER_DEFINES_SVH
`define TURRET_MOTOR_DRIVE_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define TMDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TMDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tmdc_pkg.sv -----
package tmdc_pkg;

	localparam logic [7:0]  NEUTRAL_PWM    = 8'd127;
	localparam logic [6:0]  SERVO_MAX      = 7'd127;
	localparam logic [15:0] TOGGLE_LOCKOUT = 16'h8001;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	localparam logic [6:0] RST_SERVO_GAIN        = 7'd18;
	localparam logic [6:0] RST_MANUAL_SPEED      = 7'd64;
	localparam logic [6:0] RST_PULSE_POWER       = 7'd22;
	localparam logic [3:0] RST_PULSE_ON_TICKS    = 4'd2;
	localparam logic [3:0] RST_PULSE_OFF_TICKS   = 4'd10;
	localparam logic [6:0] RST_DEAD_BAND         = 7'd2;
	localparam logic [7:0] RST_PULSE_BAND        = 8'd14;
	localparam logic [7:0] RST_TOGGLE_HOLD_TICKS = 8'd20;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SERVO_GAIN        = 3'd0,
		REG_MANUAL_SPEED      = 3'd1,
		REG_PULSE_POWER       = 3'd2,
		REG_PULSE_ON_TICKS    = 3'd3,
		REG_PULSE_OFF_TICKS   = 3'd4,
		REG_DEAD_BAND         = 3'd5,
		REG_PULSE_BAND        = 3'd6,
		REG_TOGGLE_HOLD_TICKS = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [6:0] servo_gain;
		logic [6:0] manual_speed;
		logic [6:0] pulse_power;
		logic [3:0] pulse_on_ticks;
		logic [3:0] pulse_off_ticks;
		logic [6:0] dead_band;
		logic [7:0] pulse_band;
		logic [7:0] toggle_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic              left_button;
		logic              right_button;
		logic signed [7:0] pan_error;
		logic              target_seen;
		logic              cw_limit;
		logic              ccw_limit;
	} in_item_t;

	typedef struct packed {
		logic [7:0] motor_pwm;
		logic       sweep_enabled;
	} out_item_t;

endpackage

// ----- rtl/tmdc_sweep.sv -----
`include "turret_motor_drive_controller_defines.svh"

module tmdc_sweep (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       left_button,
	input  logic       right_button,
	input  logic [7:0] hold_ticks,
	output logic       sweep_q
);
	import tmdc_pkg::*;

	logic [15:0] count_q;
	logic [15:0] count_inc;
	logic [15:0] count_d;
	logic        sweep_d;
	logic        both;

	assign both      = left_button & right_button;
	assign count_inc = count_q + 16'd1;

	always_comb begin
		count_d = count_q;
		sweep_d = sweep_q;
		if (both) begin
			if ($signed(count_inc) >= $signed({8'd0, hold_ticks})) begin
				sweep_d = ~sweep_q;
				count_d = TOGGLE_LOCKOUT;
			end else begin
				count_d = count_inc;
			end
		end else begin
			count_d = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd0;
			sweep_q <= 1'b0;
		end else if (step) begin
			count_q <= count_d;
			sweep_q <= sweep_d;
		end
	end

	`TMDC_ASSERT_NEXT(a_sweep_idle_hold, clk, arst_n, !step, $stable(sweep_q) && $stable(count_q), "sweep state moved without a transaction")
	`TMDC_ASSERT_NEXT(a_count_clear, clk, arst_n, step && !both, count_q == 16'd0, "hold counter not cleared on release")

endmodule

// ----- rtl/tmdc_drive.sv -----
`include "turret_motor_drive_controller_defines.svh"

module tmdc_drive (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  tmdc_pkg::in_item_t  item,
	input  tmdc_pkg::cfg_t      cfg,
	output logic [7:0]          pwm_q
);
	import tmdc_pkg::*;

	logic [3:0]  countdown_q;
	logic        phase_on_q;
	logic [7:0]  pwm_d;
	logic [3:0]  countdown_d;
	logic        phase_on_d;
	logic        neg;
	logic [7:0]  err_u;
	logic [7:0]  mag;
	logic [14:0] prod;
	logic [9:0]  quot;
	logic [6:0]  servo_mag;
	logic [7:0]  manual_up;
	logic [7:0]  manual_dn;
	logic [7:0]  pulse_up;
	logic [7:0]  pulse_dn;
	logic [7:0]  servo_up;
	logic [7:0]  servo_dn;

	assign neg       = item.pan_error[7];
	assign err_u     = item.pan_error;
	assign mag       = neg ? (~err_u + 8'd1) : err_u;
	assign prod      = {7'd0, mag} * {8'd0, cfg.servo_gain};
	assign quot      = prod[14:5];
	assign servo_mag = (quot > {3'd0, SERVO_MAX}) ? SERVO_MAX : quot[6:0];
	assign manual_up = NEUTRAL_PWM + {1'b0, cfg.manual_speed};
	assign manual_dn = NEUTRAL_PWM - {1'b0, cfg.manual_speed};
	assign pulse_up  = NEUTRAL_PWM + {1'b0, cfg.pulse_power};
	assign pulse_dn  = NEUTRAL_PWM - {1'b0, cfg.pulse_power};
	assign servo_up  = NEUTRAL_PWM + {1'b0, servo_mag};
	assign servo_dn  = NEUTRAL_PWM - {1'b0, servo_mag};

	always_comb begin
		pwm_d       = pwm_q;
		countdown_d = countdown_q;
		phase_on_d  = phase_on_q;
		if (item.left_button != item.right_button) begin
			if (item.right_button) begin
				if (!(item.cw_limit && cfg.manual_speed != 7'd0)) begin
					pwm_d = manual_up;
				end
			end else begin
				if (!(item.ccw_limit && cfg.manual_speed != 7'd0)) begin
					pwm_d = manual_dn;
				end
			end
		end else if (item.target_seen && mag >= {1'b0, cfg.dead_band}) begin
			if (mag < cfg.pulse_band) begin
				if (mag != 8'd0) begin
					if (countdown_q == 4'd0) begin
						phase_on_d  = ~phase_on_q;
						countdown_d = phase_on_q ? cfg.pulse_off_ticks : cfg.pulse_on_ticks;
					end else begin
						countdown_d = countdown_q - 4'd1;
					end
					if (phase_on_d) begin
						pwm_d = neg ? pulse_dn : pulse_up;
					end else begin
						pwm_d = NEUTRAL_PWM;
					end
				end
			end else begin
				if (neg) begin
					if (!(item.ccw_limit && servo_mag != 7'd0)) begin
						pwm_d = servo_dn;
					end
				end else begin
					if (!(item.cw_limit && servo_mag != 7'd0)) begin
						pwm_d = servo_up;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_q       <= NEUTRAL_PWM;
			countdown_q <= 4'd0;
			phase_on_q  <= 1'b0;
		end else if (step) begin
			pwm_q       <= pwm_d;
			countdown_q <= countdown_d;
			phase_on_q  <= phase_on_d;
		end
	end

	`TMDC_ASSERT_NEXT(a_drive_idle_hold, clk, arst_n, !step, $stable(pwm_q) && $stable(countdown_q) && $stable(phase_on_q), "drive state moved without a transaction")

endmodule

// ----- rtl/turret_motor_drive_controller.sv -----
// Turret pan motor drive. Takes one transaction per clock on the cmd channel while
// cmd_stall is low and returns one result per transaction on the res channel:
// the item is held in the input register while the drive and sweep logic
// evaluate it, and an advance then loads the state registers, which also serve as the
// result register. Sustained rate is one item per cycle while res_stall stays low;
// the input register takes one more item while a finished result waits. Configuration
// writes on cfg_write_en are registered into cfg_q and must only be issued while no
// transaction is in flight.
`include "turret_motor_drive_controller_defines.svh"

module turret_motor_drive_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  tmdc_pkg::in_item_t                cmd_data,
	output logic                              res_valid,
	input  logic                              res_stall,
	output tmdc_pkg::out_item_t               res_data,
	input  logic                              cfg_write_en,
	input  logic [tmdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tmdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tmdc_pkg::*;

	cfg_t       cfg_q;
	in_item_t   item_s1;
	logic       valid_s1;
	logic       res_valid_q;
	logic       advance;
	logic       accept;
	logic [7:0] pwm_q;
	logic       sweep_q;

	assign advance   = valid_s1 & (~res_valid_q | ~res_stall);
	assign cmd_stall = valid_s1 & ~advance;
	assign accept    = cmd_valid & ~cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.servo_gain        <= RST_SERVO_GAIN;
			cfg_q.manual_speed      <= RST_MANUAL_SPEED;
			cfg_q.pulse_power       <= RST_PULSE_POWER;
			cfg_q.pulse_on_ticks    <= RST_PULSE_ON_TICKS;
			cfg_q.pulse_off_ticks   <= RST_PULSE_OFF_TICKS;
			cfg_q.dead_band         <= RST_DEAD_BAND;
			cfg_q.pulse_band        <= RST_PULSE_BAND;
			cfg_q.toggle_hold_ticks <= RST_TOGGLE_HOLD_TICKS;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SERVO_GAIN:        cfg_q.servo_gain        <= cfg_data[6:0];
				REG_MANUAL_SPEED:      cfg_q.manual_speed      <= cfg_data[6:0];
				REG_PULSE_POWER:       cfg_q.pulse_power       <= cfg_data[6:0];
				REG_PULSE_ON_TICKS:    cfg_q.pulse_on_ticks    <= cfg_data[3:0];
				REG_PULSE_OFF_TICKS:   cfg_q.pulse_off_ticks   <= cfg_data[3:0];
				REG_DEAD_BAND:         cfg_q.dead_band         <= cfg_data[6:0];
				REG_PULSE_BAND:        cfg_q.pulse_band        <= cfg_data;
				REG_TOGGLE_HOLD_TICKS: cfg_q.toggle_hold_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd_data;
		end
	end

	tmdc_drive u_drive (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.pwm_q  (pwm_q)
	);

	tmdc_sweep u_sweep (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.left_button  (item_s1.left_button),
		.right_button (item_s1.right_button),
		.hold_ticks   (cfg_q.toggle_hold_ticks),
		.sweep_q      (sweep_q)
	);

	assign res_valid              = res_valid_q;
	assign res_data.motor_pwm     = pwm_q;
	assign res_data.sweep_enabled = sweep_q;

	`TMDC_ASSERT_NEXT(a_advance_gives_result, clk, arst_n, advance, res_valid, "processed transaction produced no result")
	`TMDC_ASSERT_NOW(a_no_overwrite, clk, arst_n, advance && res_valid_q, !res_stall, "result overwritten while stalled")

endmodule

// ----- tb/sv/tb_turret_motor_drive_controller.sv -----
module tb_turret_motor_drive_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import tmdc_pkg::*;

	localparam int NUM_DIR    = 25;
	localparam int NUM_RANDOM = 800;
	localparam int NUM_PHASES = 6;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} stim_t;

	// left, right, error, in view, cw limit, ccw limit, repeat, typed, pwm, sweep
	typedef struct {
		int l;
		int r;
		int err;
		int vis;
		int cw;
		int ccw;
		int rep;
		int typed;
		int pwm;
		int sw;
	} row_t;

	row_t dir_tab [NUM_DIR] = '{
		'{0, 0,    0, 0, 0, 0,  1, 1, 127, 0},
		'{0, 1,    0, 0, 0, 0,  1, 1, 191, 0},
		'{0, 1,    0, 0, 1, 0,  1, 1, 191, 0},
		'{1, 0,    0, 0, 0, 0,  1, 1,  63, 0},
		'{1, 0,    0, 0, 0, 1,  1, 1,  63, 0},
		'{1, 0,    0, 0, 1, 0,  1, 1,  63, 0},
		'{0, 0,    1, 1, 0, 0,  1, 1,  63, 0},
		'{0, 0,  127, 1, 0, 0,  1, 1, 198, 0},
		'{0, 0, -128, 1, 0, 0,  1, 1,  55, 0},
		'{0, 0,  127, 1, 1, 0,  1, 1,  55, 0},
		'{0, 0, -128, 1, 0, 1,  1, 1,  55, 0},
		'{0, 0,    5, 1, 0, 0,  1, 0,   0, 0},
		'{0, 0,    5, 1, 0, 0,  1, 0,   0, 0},
		'{0, 0,   -5, 1, 0, 0,  1, 0,   0, 0},
		'{0, 0,    5, 1, 0, 0,  1, 0,   0, 0},
		'{0, 0,   13, 1, 1, 1,  1, 0,   0, 0},
		'{0, 0,   14, 1, 0, 0,  1, 0,   0, 0},
		'{0, 0,  -14, 1, 0, 0,  1, 0,   0, 0},
		'{0, 0,   -2, 1, 0, 0,  1, 0,   0, 0},
		'{0, 0,  100, 0, 1, 1,  1, 0,   0, 0},
		'{1, 1,   -1, 0, 0, 0, 19, 0,   0, 0},
		'{1, 1,    0, 0, 0, 0,  1, 1, 127, 1},
		'{1, 1,  127, 1, 0, 0,  4, 0,   0, 0},
		'{0, 1, -128, 1, 0, 0,  1, 1, 191, 1},
		'{0, 0,    0, 1, 0, 0,  1, 0,   0, 0}
	};

	cfg_t phase_cfg [NUM_PHASES-2] = '{
		'{7'd0,   7'd0,   7'd0,   4'd0,  4'd0,  7'd0,   8'd0,   8'd0},
		'{7'd127, 7'd127, 7'd127, 4'd15, 4'd15, 7'd127, 8'd128, 8'd255},
		'{7'd127, 7'd100, 7'd127, 4'd0,  4'd0,  7'd0,   8'd255, 8'd1},
		'{7'd45,  7'd30,  7'd60,  4'd3,  4'd5,  7'd4,   8'd40,  8'd10}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	in_item_t  cmd_data = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_item_t res_data;
	logic      cfg_write_en = 1'b0;
	cfg_reg_t  cfg_index = REG_SERVO_GAIN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int send_idle_pct = 9;
	int recv_idle_pct = 50;
	int fail_count = 0;
	int rnd_count = 0;

	stim_t     cur_tx;
	out_item_t drive_expect_q [$];

	cfg_t        drive_cfg;
	logic [7:0]  hold_pwm;
	logic [3:0]  pulse_left;
	logic        pulse_on;
	logic [15:0] both_count;
	logic        sweep_state;

	turret_motor_drive_controller DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd_data    (cmd_data),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_data    (res_data),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	function automatic void drive_limited(int drive, logic cw, logic ccw);
		if ((cw && drive > 0) || (ccw && drive < 0))
			return;
		hold_pwm = 8'(int'(NEUTRAL_PWM) + drive);
	endfunction

	function automatic void pulse_step(int err);
		if (err == 0)
			return;
		if (pulse_left == 4'd0) begin
			pulse_on = !pulse_on;
			pulse_left = pulse_on ? drive_cfg.pulse_on_ticks : drive_cfg.pulse_off_ticks;
		end else begin
			pulse_left = pulse_left - 4'd1;
		end
		if (!pulse_on)
			hold_pwm = NEUTRAL_PWM;
		else if (err > 0)
			hold_pwm = 8'(int'(NEUTRAL_PWM) + int'(drive_cfg.pulse_power));
		else
			hold_pwm = 8'(int'(NEUTRAL_PWM) - int'(drive_cfg.pulse_power));
	endfunction

	function automatic void servo_step(int err, logic cw, logic ccw);
		int q;
		q = (err * int'(drive_cfg.servo_gain)) / 32;
		if (q > int'(SERVO_MAX))
			q = int'(SERVO_MAX);
		if (q < -int'(SERVO_MAX))
			q = -int'(SERVO_MAX);
		drive_limited(q, cw, ccw);
	endfunction

	function automatic out_item_t compute_drive(in_item_t it);
		int err;
		int mag;
		int cnt;
		out_item_t r;
		err = int'($signed(it.pan_error));
		if (it.left_button && it.right_button) begin
			both_count = both_count + 16'd1;
			cnt = int'($signed(both_count));
			if (cnt >= int'(drive_cfg.toggle_hold_ticks)) begin
				sweep_state = !sweep_state;
				both_count = TOGGLE_LOCKOUT;
			end
		end else begin
			both_count = '0;
		end
		if (it.left_button == it.right_button) begin
			if (it.target_seen) begin
				mag = (err < 0) ? -err : err;
				if (mag >= int'(drive_cfg.dead_band)) begin
					if (mag < int'(drive_cfg.pulse_band))
						pulse_step(err);
					else
						servo_step(err, it.cw_limit, it.ccw_limit);
				end
			end
		end else if (it.left_button) begin
			drive_limited(-int'(drive_cfg.manual_speed), it.cw_limit, it.ccw_limit);
		end else begin
			drive_limited(int'(drive_cfg.manual_speed), it.cw_limit, it.ccw_limit);
		end
		r.motor_pwm = hold_pwm;
		r.sweep_enabled = sweep_state;
		return r;
	endfunction

	function automatic in_item_t make_item(int l, int r, int err, int vis, int cw, int ccw);
		in_item_t it;
		it.left_button = l[0];
		it.right_button = r[0];
		it.pan_error = 8'(err);
		it.target_seen = vis[0];
		it.cw_limit = cw[0];
		it.ccw_limit = ccw[0];
		return it;
	endfunction

	function automatic int pick_error();
		int lo;
		int hi;
		int mag;
		lo = (int'(drive_cfg.dead_band) > 128) ? 128 : int'(drive_cfg.dead_band);
		hi = (int'(drive_cfg.pulse_band) > 128) ? 128 : int'(drive_cfg.pulse_band);
		case ($urandom_range(4))
			0: mag = $urandom_range(lo, 0);
			1: mag = $urandom_range(hi, lo);
			2: mag = $urandom_range(128, hi);
			3: return int'($signed(8'($urandom_range(255))));
			default: begin
				case ($urandom_range(3))
					0: return 127;
					1: return -128;
					2: return -127;
					default: return 0;
				endcase
			end
		endcase
		if (mag >= 128)
			return -128;
		return $urandom_range(1) ? mag : -mag;
	endfunction

	task automatic note_fail(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		out_item_t pred;
		out_item_t want;
		if (cmd_valid && !cmd_stall) begin
			pred = compute_drive(cur_tx.item);
			drive_expect_q.push_back(cur_tx.typed ? cur_tx.want : pred);
		end
		if (res_valid && !res_stall) begin
			if (drive_expect_q.size() == 0) begin
				note_fail($sformatf("unexpected result: pwm %0d sweep %0d",
					res_data.motor_pwm, res_data.sweep_enabled));
			end else begin
				want = drive_expect_q.pop_front();
				if (res_data.motor_pwm !== want.motor_pwm ||
				    res_data.sweep_enabled !== want.sweep_enabled)
					note_fail($sformatf("mismatch: expected pwm %0d sweep %0d, got pwm %0d sweep %0d",
						want.motor_pwm, want.sweep_enabled,
						res_data.motor_pwm, res_data.sweep_enabled));
			end
		end
	end

	task automatic send_tx(stim_t t);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		cur_tx <= t;
		cmd_data <= t.item;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!(cmd_valid && !cmd_stall)) @(posedge clk);
	endtask

	task automatic wait_results_done();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (drive_expect_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_SERVO_GAIN:        drive_cfg.servo_gain = val[6:0];
			REG_MANUAL_SPEED:      drive_cfg.manual_speed = val[6:0];
			REG_PULSE_POWER:       drive_cfg.pulse_power = val[6:0];
			REG_PULSE_ON_TICKS:    drive_cfg.pulse_on_ticks = val[3:0];
			REG_PULSE_OFF_TICKS:   drive_cfg.pulse_off_ticks = val[3:0];
			REG_DEAD_BAND:         drive_cfg.dead_band = val[6:0];
			REG_PULSE_BAND:        drive_cfg.pulse_band = val;
			REG_TOGGLE_HOLD_TICKS: drive_cfg.toggle_hold_ticks = val;
			default: ;
		endcase
	endtask

	task automatic load_cfg(cfg_t c);
		write_reg(REG_SERVO_GAIN, {1'b0, c.servo_gain});
		write_reg(REG_MANUAL_SPEED, {1'b0, c.manual_speed});
		write_reg(REG_PULSE_POWER, {1'b0, c.pulse_power});
		write_reg(REG_PULSE_ON_TICKS, {4'd0, c.pulse_on_ticks});
		write_reg(REG_PULSE_OFF_TICKS, {4'd0, c.pulse_off_ticks});
		write_reg(REG_DEAD_BAND, {1'b0, c.dead_band});
		write_reg(REG_PULSE_BAND, c.pulse_band);
		write_reg(REG_TOGGLE_HOLD_TICKS, c.toggle_hold_ticks);
		cfg_write_en <= 1'b0;
	endtask

	// tracking runs, manual runs, both-button holds and plain noise
	task automatic run_burst();
		int kind;
		int len;
		int side;
		stim_t t;
		kind = $urandom_range(99);
		side = $urandom_range(1);
		if (kind < 50)
			len = $urandom_range(20, 1);
		else if (kind < 65)
			len = $urandom_range(8, 1);
		else if (kind < 80)
			len = $urandom_range(int'(drive_cfg.toggle_hold_ticks) + 2, 1);
		else
			len = $urandom_range(6, 1);
		t.typed = 1'b0;
		t.want = '0;
		for (int k = 0; k < len; k++) begin
			if (rnd_count < NUM_RANDOM / 3) begin
				send_idle_pct = 9;
				recv_idle_pct = 50;
			end else if (rnd_count < 2 * NUM_RANDOM / 3) begin
				send_idle_pct = 50;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (kind < 50)
				t.item = make_item(0, 0, pick_error(), $urandom_range(9) != 0,
					$urandom_range(4) == 0, $urandom_range(4) == 0);
			else if (kind < 65)
				t.item = make_item(side == 0, side == 1, pick_error(), $urandom_range(1),
					$urandom_range(9) < 3, $urandom_range(9) < 3);
			else if (kind < 80)
				t.item = make_item(1, 1, pick_error(), $urandom_range(1),
					$urandom_range(1), $urandom_range(1));
			else
				t.item = in_item_t'(13'($urandom_range(8191)));
			send_tx(t);
			rnd_count++;
		end
	endtask

	initial begin
		stim_t t;
		cfg_t c;
		drive_cfg = '{RST_SERVO_GAIN, RST_MANUAL_SPEED, RST_PULSE_POWER, RST_PULSE_ON_TICKS,
			RST_PULSE_OFF_TICKS, RST_DEAD_BAND, RST_PULSE_BAND, RST_TOGGLE_HOLD_TICKS};
		hold_pwm = NEUTRAL_PWM;
		pulse_left = '0;
		pulse_on = 1'b0;
		both_count = '0;
		sweep_state = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++) begin
			for (int k = 0; k < dir_tab[i].rep; k++) begin
				t.item = make_item(dir_tab[i].l, dir_tab[i].r, dir_tab[i].err,
					dir_tab[i].vis, dir_tab[i].cw, dir_tab[i].ccw);
				t.typed = dir_tab[i].typed[0];
				t.want.motor_pwm = 8'(dir_tab[i].pwm);
				t.want.sweep_enabled = dir_tab[i].sw[0];
				send_tx(t);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				wait_results_done();
				if (ph < NUM_PHASES - 1) begin
					c = phase_cfg[ph-1];
				end else begin
					c.servo_gain = 7'($urandom_range(127));
					c.manual_speed = 7'($urandom_range(127));
					c.pulse_power = 7'($urandom_range(127));
					c.pulse_on_ticks = 4'($urandom_range(15));
					c.pulse_off_ticks = 4'($urandom_range(15));
					c.dead_band = 7'($urandom_range(127));
					c.pulse_band = 8'($urandom_range(255));
					c.toggle_hold_ticks = 8'($urandom_range(255));
				end
				load_cfg(c);
			end
			while (rnd_count < (ph + 1) * NUM_RANDOM / NUM_PHASES) begin
				run_burst();
				if ($urandom_range(15) == 0)
					wait_results_done();
			end
		end

		wait_results_done();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && drive_expect_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tmdc_pkg.sv
rtl/tmdc_sweep.sv
rtl/tmdc_drive.sv
rtl/turret_motor_drive_controller.sv
tb/sv/tb_turret_motor_drive_controller.sv
